@@ rtl/hslpa_pkg.sv @@
// Shared constants, codes and widths for the HSL pixel adjust block.
`default_nettype none

package hslpa_pkg;

	// Channel and fixed-point widths.
	localparam int CH_W    = 16;
	localparam int FRAC_W  = 24;
	localparam int SL_W    = FRAC_W + 1;
	localparam int HUE_W   = 15;

	localparam logic [SL_W-1:0] UNIT_ONE = SL_W'(1) << FRAC_W;

	// Hue units are 1/64 degree.
	localparam int HUE_TURN  = 23040;
	localparam int HUE_SIXTH = 3840;
	localparam int KSTEP     = 1920;

	// Hue offsets used when converting back to each channel.
	localparam logic [HUE_W-1:0] RED_OFF   = HUE_W'(0);
	localparam logic [HUE_W-1:0] GREEN_OFF = HUE_W'(8 * KSTEP);
	localparam logic [HUE_W-1:0] BLUE_OFF  = HUE_W'(4 * KSTEP);

	// Shared restoring divider geometry.
	localparam int DIV_NW = 43;
	localparam int DIV_DW = 18;
	localparam int DIV_QW = 25;

	// Stage counts of the sub-units and of the whole pipeline.
	localparam int PUSH_LAT = 3;
	localparam int CHAN_LAT = 6;
	localparam int LAT      = 2 + DIV_QW + PUSH_LAT + CHAN_LAT;

	typedef enum logic [1:0] {
		REG_HUE_SHIFT = 2'd0,
		REG_SAT_AMT   = 2'd1,
		REG_LIGHT_AMT = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEL_RED   = 2'd0,
		SEL_GREEN = 2'd1,
		SEL_BLUE  = 2'd2
	} top_sel_t;

endpackage

`default_nettype wire

@@ rtl/hslpa_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module hslpa_div
	import hslpa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [DIV_NW-1:0] num,
	input  wire logic [DIV_DW-1:0] den,
	output logic      [DIV_QW-1:0] quo
);

	logic [DIV_NW-1:0] rem_s [DIV_QW];
	logic [DIV_DW-1:0] den_s [DIV_QW];
	logic [DIV_QW-1:0] quo_s [DIV_QW];

	for (genvar i = 0; i < DIV_QW; i++) begin : g_stage
		localparam int B = DIV_QW - 1 - i;
		logic [DIV_NW-1:0] rem_in;
		logic [DIV_DW-1:0] den_in;
		logic [DIV_QW-1:0] quo_in;
		logic [DIV_NW-1:0] dsh;
		logic              fits;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		always_comb begin
			dsh  = DIV_NW'(den_in) << B;
			fits = (rem_in >= dsh);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= fits ? (rem_in - dsh) : rem_in;
				den_s[i] <= den_in;
				quo_s[i] <= quo_in | (fits ? (DIV_QW'(1) << B) : '0);
			end
		end
	end

	assign quo = quo_s[DIV_QW-1];

endmodule

`default_nettype wire

@@ rtl/hslpa_push.sv @@
// Saturation or lightness push toward full or toward zero by a percentage.
`default_nettype none

module hslpa_push
	import hslpa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [SL_W-1:0]   x,
	input  wire logic signed [7:0] amt,
	output logic      [SL_W-1:0]   y
);

	// floor(2^34 / 25); the quotient may come out one low and is corrected.
	localparam logic [29:0] RECIP25 = 30'd687194767;

	logic            pos;
	logic [6:0]      pct;
	logic [SL_W-1:0] base;
	logic [28:0]     z;
	logic [24:0]     q0;
	logic [29:0]     rem;
	logic [24:0]     q;

	logic [31:0]     prod_s1;
	logic [SL_W-1:0] x_s1;
	logic            pos_s1;
	logic [58:0]     mult_s2;
	logic [28:0]     z_s2;
	logic [SL_W-1:0] x_s2;
	logic            pos_s2;

	always_comb begin
		pos  = !amt[7];
		pct  = pos ? 7'(amt) : 7'(8'sd100 + amt);
		base = pos ? (UNIT_ONE - x) : x;
		// Round to nearest: floor((2p + 100) / 200) = floor(floor((2p + 100) / 8) / 25).
		z    = 29'((33'(prod_s1) << 1) + 33'd100 >> 3);
		q0   = mult_s2[58:34];
		rem  = 30'(z_s2) - 30'(q0) * 30'd25;
		q    = (rem >= 30'd25) ? (q0 + 25'd1) : q0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 32'(base) * 32'(pct);
			x_s1    <= x;
			pos_s1  <= pos;
			mult_s2 <= 59'(z) * 59'(RECIP25);
			z_s2    <= z;
			x_s2    <= x_s1;
			pos_s2  <= pos_s1;
			y       <= pos_s2 ? SL_W'(x_s2 + SL_W'(q)) : SL_W'(q);
		end
	end

endmodule

`default_nettype wire

@@ rtl/hslpa_chan.sv @@
// Conversion of hue, saturation and lightness back to one color channel.
`default_nettype none

module hslpa_chan
	import hslpa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [HUE_W-1:0]  off,
	input  wire logic [HUE_W-1:0]  hue,
	input  wire logic [SL_W-1:0]   sat,
	input  wire logic [SL_W-1:0]   lgt,
	output logic      [CH_W-1:0]   chan
);

	// floor(2^32 / 15); the quotient may come out one low and is corrected.
	localparam logic [28:0] RECIP15 = 29'd286331153;
	// 1920 * 2^24, half of the doubled divisor, added to the doubled product.
	localparam logic [59:0] ROUND_BIAS = 60'd32212254720;

	logic [15:0]        ksum;
	logic [HUE_W-1:0]   k;
	logic signed [16:0] ta;
	logic signed [16:0] tb;
	logic signed [16:0] tmin;
	logic signed [11:0] tcl;
	logic [SL_W-1:0]    lc;
	logic [23:0]        m;
	logic [59:0]        xsum;
	logic [27:0]        ydiv;
	logic [24:0]        q0;
	logic [28:0]        rem;
	logic [24:0]        q;
	logic signed [26:0] v;
	logic [SL_W-1:0]    vcl;
	logic [40:0]        scaled;

	logic signed [11:0] t_s1;
	logic [23:0]        m_s1;
	logic [SL_W-1:0]    s_s1;
	logic [SL_W-1:0]    l_s1;
	logic [47:0]        sm_s2;
	logic [10:0]        tm_s2;
	logic               neg_s2;
	logic [SL_W-1:0]    l_s2;
	logic [58:0]        p_s3;
	logic               neg_s3;
	logic [SL_W-1:0]    l_s3;
	logic [56:0]        ym_s4;
	logic [27:0]        y_s4;
	logic               neg_s4;
	logic [SL_W-1:0]    l_s4;
	logic [SL_W-1:0]    v_s5;

	always_comb begin
		ksum = 16'(off) + 16'(hue);
		k    = (ksum >= 16'(HUE_TURN)) ? HUE_W'(ksum - 16'(HUE_TURN)) : HUE_W'(ksum);
		ta   = signed'(17'(k)) - 17'sd5760;
		tb   = 17'sd17280 - signed'(17'(k));
		tmin = (tb < ta) ? tb : ta;
		if (tmin > 17'sd1920) begin
			tcl = 12'sd1920;
		end else if (tmin < -17'sd1920) begin
			tcl = -12'sd1920;
		end else begin
			tcl = 12'(tmin);
		end
		lc = UNIT_ONE - lgt;
		m  = (lgt < lc) ? 24'(lgt) : 24'(lc);

		xsum = (60'(p_s3) << 1) + ROUND_BIAS;
		ydiv = xsum[59:32];

		q0  = ym_s4[56:32];
		rem = 29'(y_s4) - 29'(q0) * 29'd15;
		q   = (rem >= 29'd15) ? (q0 + 25'd1) : q0;
		v   = neg_s4 ? (signed'(27'(l_s4)) + signed'(27'(q)))
		             : (signed'(27'(l_s4)) - signed'(27'(q)));
		if (v < 27'sd0) begin
			vcl = '0;
		end else if (v > signed'(27'(UNIT_ONE))) begin
			vcl = UNIT_ONE;
		end else begin
			vcl = SL_W'(v);
		end

		scaled = (41'(v_s5) << 16) - 41'(v_s5) + 41'(1 << 23);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= tcl;
			m_s1   <= m;
			s_s1   <= sat;
			l_s1   <= lgt;
			sm_s2  <= 48'(s_s1) * 48'(m_s1);
			tm_s2  <= (t_s1 < 12'sd0) ? 11'(-t_s1) : 11'(t_s1);
			neg_s2 <= (t_s1 < 12'sd0);
			l_s2   <= l_s1;
			p_s3   <= 59'(sm_s2) * 59'(tm_s2);
			neg_s3 <= neg_s2;
			l_s3   <= l_s2;
			ym_s4  <= 57'(ydiv) * 57'(RECIP15);
			y_s4   <= ydiv;
			neg_s4 <= neg_s3;
			l_s4   <= l_s3;
			v_s5   <= vcl;
			chan   <= scaled[39:24];
		end
	end

endmodule

`default_nettype wire

@@ rtl/hsl_pixel_adjust.sv @@
// Top level of the HSL pixel adjust pipeline.
`default_nettype none

//  Channel   Direction  Beat contents (lowest bit first)
//  s_axis    in         tdata: red_in[15:0], green_in[15:0], blue_in[15:0]
//  m_axis    out        tdata: red_out[15:0], green_out[15:0], blue_out[15:0]
//  cfg       in         write: 0 hue_shift, 1 saturation_amount, 2 lightness_amount
//
//  One pixel is accepted per clock while the output beat is not held.
//  The latency is set mostly by the 25 stages of the restoring dividers that
//  form saturation and hue, one quotient bit per stage; lightness is a division
//  by a constant and waits beside them in a delay line.
//  Reset clears the valid bits and the three registers to zero.
//  When the output beat is held, every stage freezes together; nothing is lost.

module hsl_pixel_adjust
	import hslpa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // red_in, green_in, blue_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [47:0] m_axis_tdata,   // red_out, green_out, blue_out
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);

	function automatic logic signed [7:0] limit_pct(input logic signed [7:0] p);
		logic signed [7:0] r;
		r = p;
		if (p > 8'sd100) begin
			r = 8'sd100;
		end else if (p < -8'sd100) begin
			r = -8'sd100;
		end
		return r;
	endfunction

	// The whole pipeline advances whenever the output stage is empty or drained.
	logic adv;

	logic signed [8:0] hue_shift_q;
	logic signed [7:0] sat_amt_q;
	logic signed [7:0] light_amt_q;
	logic [LAT-1:0]    vld_q;

	logic [CH_W-1:0] red;
	logic [CH_W-1:0] grn;
	logic [CH_W-1:0] blu;
	logic [CH_W-1:0] tmax;
	logic [CH_W-1:0] tmin;
	top_sel_t        sel;
	logic signed [16:0] diff;

	logic [16:0]        den0;
	logic [14:0]        hbase;
	logic signed [32:0] hnum;
	logic [24:0]        lmid;
	logic [8:0]         lq;
	logic [24:0]        lrem;

	logic [DIV_QW-1:0]  quo_l;
	logic [DIV_QW-1:0]  quo_s;
	logic [DIV_QW-1:0]  quo_h;
	logic [HUE_W-1:0]   hue0;
	logic signed [17:0] hv;
	logic [HUE_W-1:0]   hwrap;
	logic [SL_W-1:0]    sat_adj;
	logic [SL_W-1:0]    light_adj;

	top_sel_t           sel_s1;
	logic [CH_W-1:0]    span_s1;
	logic [16:0]        sum_s1;
	logic signed [16:0] diff_s1;

	logic [SL_W-1:0]    light_s2;
	logic [DIV_NW-1:0]  snum_s2;
	logic [DIV_DW-1:0]  sden_s2;
	logic [DIV_NW-1:0]  hnum_s2;
	logic [DIV_DW-1:0]  hden_s2;

	logic [SL_W-1:0]    light_dly_s [DIV_QW];

	logic [HUE_W-1:0]   hue_s28;
	logic [HUE_W-1:0]   hue_s29;
	logic [HUE_W-1:0]   hue_s30;

	logic [CH_W-1:0]    red_out;
	logic [CH_W-1:0]    green_out;
	logic [CH_W-1:0]    blue_out;

	assign adv           = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[LAT-1];
	assign m_axis_tdata  = {blue_out, green_out, red_out};

	assign red = s_axis_tdata[15:0];
	assign grn = s_axis_tdata[31:16];
	assign blu = s_axis_tdata[47:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_shift_q <= '0;
			sat_amt_q   <= '0;
			light_amt_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_HUE_SHIFT: hue_shift_q <= signed'(cfg_data);
				REG_SAT_AMT:   sat_amt_q   <= limit_pct(signed'(cfg_data[7:0]));
				REG_LIGHT_AMT: light_amt_q <= limit_pct(signed'(cfg_data[7:0]));
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	// Stage 1: largest and smallest channel. Ties go to red, then green.
	always_comb begin
		tmax = red;
		sel  = SEL_RED;
		if (grn > tmax) begin
			tmax = grn;
			sel  = SEL_GREEN;
		end
		if (blu > tmax) begin
			tmax = blu;
			sel  = SEL_BLUE;
		end
		tmin = red;
		if (grn < tmin) begin
			tmin = grn;
		end
		if (blu < tmin) begin
			tmin = blu;
		end
		case (sel)
			SEL_RED:   diff = signed'(17'(grn)) - signed'(17'(blu));
			SEL_GREEN: diff = signed'(17'(blu)) - signed'(17'(red));
			default:   diff = signed'(17'(red)) - signed'(17'(grn));
		endcase
	end

	// Stage 2: numerators and denominators of the two divisions, each biased
	// so that the truncating divider rounds to nearest. A gray pixel divides
	// zero by one, which gives hue and saturation zero.
	always_comb begin
		den0 = (sum_s1 > 17'(65535)) ? (17'd131070 - sum_s1) : sum_s1;
		case (sel_s1)
			SEL_RED:   hbase = 15'(6 * HUE_SIXTH);
			SEL_GREEN: hbase = 15'(2 * HUE_SIXTH);
			default:   hbase = 15'(4 * HUE_SIXTH);
		endcase
		hnum = (33'(diff_s1) * 33'sd3840) + signed'(33'(hbase) * 33'(span_s1));

		// Lightness is sum * 2^24 / 131070 rounded to nearest. Since
		// 2^23 = 128 * 65535 + 128, that is 128 * sum plus
		// floor((128 * sum + 32767) / 65535), a small quotient that is
		// either the value shifted down by 16 or one more.
		lmid = (25'(sum_s1) << 7) + 25'd32767;
		lq   = lmid[24:16];
		lrem = lmid - (25'(lq) << 16) + 25'(lq);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s1  <= sel;
			span_s1 <= tmax - tmin;
			sum_s1  <= 17'(tmax) + 17'(tmin);
			diff_s1 <= diff;

			light_s2 <= (SL_W'(sum_s1) << 7) + SL_W'(lq) + SL_W'(lrem >= 25'd65535);
			if (span_s1 == '0) begin
				snum_s2 <= '0;
				sden_s2 <= DIV_DW'(1);
				hnum_s2 <= '0;
				hden_s2 <= DIV_DW'(1);
			end else begin
				snum_s2 <= (DIV_NW'(span_s1) << 25) + DIV_NW'(den0);
				sden_s2 <= DIV_DW'(den0) << 1;
				hnum_s2 <= (DIV_NW'(unsigned'(hnum)) << 1) + DIV_NW'(span_s1);
				hden_s2 <= DIV_DW'(span_s1) << 1;
			end
		end
	end

	// Lightness keeps pace with the divider stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			light_dly_s[0] <= light_s2;
			for (int i = 1; i < DIV_QW; i++) begin
				light_dly_s[i] <= light_dly_s[i-1];
			end
		end
	end

	assign quo_l = light_dly_s[DIV_QW-1];

	hslpa_div u_div_sat (
		.clk (clk),
		.en  (adv),
		.num (snum_s2),
		.den (sden_s2),
		.quo (quo_s)
	);

	hslpa_div u_div_hue (
		.clk (clk),
		.en  (adv),
		.num (hnum_s2),
		.den (hden_s2),
		.quo (quo_h)
	);

	// Hue rotation: the raw hue lies below two turns, the shifted one below three.
	always_comb begin
		hue0 = (quo_h >= DIV_QW'(HUE_TURN)) ? HUE_W'(quo_h - DIV_QW'(HUE_TURN))
		                                    : HUE_W'(quo_h);
		hv   = signed'(18'(hue0)) + (18'(hue_shift_q) <<< 6) + 18'sd23040;
		if (hv >= 18'sd46080) begin
			hwrap = HUE_W'(hv - 18'sd46080);
		end else if (hv >= 18'sd23040) begin
			hwrap = HUE_W'(hv - 18'sd23040);
		end else begin
			hwrap = HUE_W'(hv);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_s28 <= hwrap;
			hue_s29 <= hue_s28;
			hue_s30 <= hue_s29;
		end
	end

	hslpa_push u_push_sat (
		.clk (clk),
		.en  (adv),
		.x   (quo_s),
		.amt (sat_amt_q),
		.y   (sat_adj)
	);

	hslpa_push u_push_light (
		.clk (clk),
		.en  (adv),
		.x   (quo_l),
		.amt (light_amt_q),
		.y   (light_adj)
	);

	hslpa_chan u_chan_red (
		.clk  (clk),
		.en   (adv),
		.off  (RED_OFF),
		.hue  (hue_s30),
		.sat  (sat_adj),
		.lgt  (light_adj),
		.chan (red_out)
	);

	hslpa_chan u_chan_green (
		.clk  (clk),
		.en   (adv),
		.off  (GREEN_OFF),
		.hue  (hue_s30),
		.sat  (sat_adj),
		.lgt  (light_adj),
		.chan (green_out)
	);

	hslpa_chan u_chan_blue (
		.clk  (clk),
		.en   (adv),
		.off  (BLUE_OFF),
		.hue  (hue_s30),
		.sat  (sat_adj),
		.lgt  (light_adj),
		.chan (blue_out)
	);

	// An accepted pixel occupies the first stage on the next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_q[0])
		else $error("accepted pixel missing from first stage");

	// A stall freezes every valid bit.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved during a stall");

	// When the pipeline advances, each valid bit moves exactly one stage.
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (vld_q[LAT-1:1] == $past(vld_q[LAT-2:0])))
		else $error("valid bits lost or duplicated");

endmodule

`default_nettype wire

@@ tb/tb_hsl_pixel_adjust.sv @@
// Self-checking testbench for the HSL pixel adjust pipeline.
`timescale 1ns / 100ps
`default_nettype none

module tb_hsl_pixel_adjust;
	import hslpa_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // red_in, green_in, blue_in
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // red_out, green_out, blue_out
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;

	typedef struct packed {
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
	} pixel_t;

	// One row of the directed table. A row with known set carries a result that
	// can be read straight off the conversion formulas.
	typedef struct {
		pixel_t pix;
		bit     known;
		pixel_t want;
	} pix_row_t;

	localparam longint ONE_FX = longint'(1) << FRAC_W;
	localparam int     FULL   = 65535;

	// Local copy of the raw values written to the three registers, sign-extended.
	int hue_deg;
	int sat_pct;
	int light_pct;

	pixel_t adjusted_q[$];
	int     errors;
	int     beats_in;
	int     beats_out;
	bit     hold_off;      // forces a long receiver stall
	int     hold_cycles;

	hsl_pixel_adjust u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Rounded division, halves away from zero; den is always positive.
	function automatic longint round_div(longint num, longint den);
		if (num >= 0) begin
			return (2 * num + den) / (2 * den);
		end
		return -((-2 * num + den) / (2 * den));
	endfunction

	function automatic int clip_pct(int p);
		return (p > 100) ? 100 : ((p < -100) ? -100 : p);
	endfunction

	// Moves a saturation or lightness value toward one or toward zero.
	function automatic longint scale_toward(longint x, int amt);
		if (amt >= 0) begin
			return x + round_div((ONE_FX - x) * amt, 100);
		end
		return round_div(x * (100 + amt), 100);
	endfunction

	// Rebuilds one channel from hue, saturation and lightness.
	function automatic logic [15:0] hsl_to_channel(longint hue, longint sat, longint lum,
	                                               longint off);
		longint k;
		longint tri_v;
		longint m;
		longint v;
		k = (off + hue) % HUE_TURN;
		tri_v = k - 3 * KSTEP;
		if (9 * KSTEP - k < tri_v) tri_v = 9 * KSTEP - k;
		if (tri_v > KSTEP) tri_v = KSTEP;
		if (tri_v < -KSTEP) tri_v = -KSTEP;
		m = (lum < ONE_FX - lum) ? lum : ONE_FX - lum;
		v = lum - round_div(sat * m * tri_v, ONE_FX * KSTEP);
		if (v < 0) v = 0;
		if (v > ONE_FX) v = ONE_FX;
		return 16'((v * FULL + ONE_FX / 2) >>> FRAC_W);
	endfunction

	// Full pixel adjustment under the current register copy.
	function automatic pixel_t adjust_pixel(pixel_t p);
		longint r, g, b, top, bot, span, sum, hue, sat, lum, den, num;
		pixel_t o;
		r = p.red;
		g = p.green;
		b = p.blue;
		top = r;
		bot = r;
		hue = 0;
		sat = 0;
		if (g > top) top = g;
		if (b > top) top = b;
		if (g < bot) bot = g;
		if (b < bot) bot = b;
		span = top - bot;
		sum = top + bot;
		lum = round_div(sum * ONE_FX, 2 * FULL);
		// A gray pixel keeps hue and saturation at zero.
		if (span != 0) begin
			den = (sum > FULL) ? (2 * FULL - sum) : sum;
			sat = round_div(span * ONE_FX, den);
			// Ties on the largest channel go to red, then green.
			if (top == r) num = HUE_SIXTH * (g - b) + 6 * HUE_SIXTH * span;
			else if (top == g) num = HUE_SIXTH * (b - r) + 2 * HUE_SIXTH * span;
			else num = HUE_SIXTH * (r - g) + 4 * HUE_SIXTH * span;
			hue = round_div(num, span) % HUE_TURN;
		end
		hue = (hue + longint'(hue_deg) * 64 + HUE_TURN) % HUE_TURN;
		sat = scale_toward(sat, clip_pct(sat_pct));
		lum = scale_toward(lum, clip_pct(light_pct));
		o.red   = hsl_to_channel(hue, sat, lum, RED_OFF);
		o.green = hsl_to_channel(hue, sat, lum, GREEN_OFF);
		o.blue  = hsl_to_channel(hue, sat, lum, BLUE_OFF);
		return o;
	endfunction

	// Register write; only called while the pipeline is empty. The local copy
	// keeps the raw values; the block clamps both amounts to +-100 when it stores them.
	task automatic write_reg(cfg_reg_t idx, logic [8:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_HUE_SHIFT: begin
				hue_deg = int'($signed(val));
			end
			REG_SAT_AMT: begin
				sat_pct = int'($signed(val[7:0]));
			end
			REG_LIGHT_AMT: begin
				light_pct = int'($signed(val[7:0]));
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_all(int hs, int sa, int la);
		write_reg(REG_HUE_SHIFT, 9'(hs));
		write_reg(REG_SAT_AMT, 9'(sa));
		write_reg(REG_LIGHT_AMT, 9'(la));
	endtask

	// Offers one beat, after a random gap when gaps is set; the expectation is queued when the
	// beat is accepted. A known row's result is checked against the predictor too.
	task automatic send_pixel(pixel_t p, bit known, pixel_t want, bit gaps);
		int gap;
		pixel_t pred;
		gap = gaps ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= p;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pred = adjust_pixel(p);
		if (known && pred != want) begin
			$error("table row disagrees with predictor: expected %h got %h", want, pred);
			errors++;
		end
		adjusted_q.push_back(known ? want : pred);
		beats_in++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (adjusted_q.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	function automatic pixel_t rand_pixel();
		pixel_t p;
		int mode;
		mode = $urandom_range(0, 9);
		p = pixel_t'({16'($urandom), 16'($urandom), 16'($urandom)});
		case (mode)
			0: p.green = p.red;                 // tie between red and green
			1: p.blue = p.green;                // tie between green and blue
			2: begin
				p.green = p.red;                // gray pixel
				p.blue = p.red;
			end
			3: p.red = (mode[0]) ? 16'hffff : 16'h0000;
			4: p.blue = p.red + 16'($urandom_range(0, 3));   // red and blue nearly equal
			default: begin
			end
		endcase
		return p;
	endfunction

	// Receiver: random stalls, plus one long forced hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= 0;
		end else if (hold_off) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= (hold_cycles == 1);
		end else if (m_axis_tvalid && m_axis_tready || !m_axis_tready) begin
			if ($urandom_range(0, 3) == 0) begin
				hold_cycles <= $urandom_range(1, 16);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Output checker, field by field against the oldest expectation.
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			beats_out++;
			if (adjusted_q.size() == 0) begin
				$error("output beat with nothing expected: %h", got);
				errors++;
			end else begin
				want = adjusted_q.pop_front();
				if (got.red !== want.red) begin
					$error("red_out expected %0d actual %0d", want.red, got.red);
					errors++;
				end
				if (got.green !== want.green) begin
					$error("green_out expected %0d actual %0d", want.green, got.green);
					errors++;
				end
				if (got.blue !== want.blue) begin
					$error("blue_out expected %0d actual %0d", want.blue, got.blue);
					errors++;
				end
			end
		end
	end

	// Hard limit: about 1000 beats with random gaps and stalls stay far below.
	initial begin
		#400000;
		$display("FAIL hsl_pixel_adjust");
		$finish;
	end

	pix_row_t dir_rows[$];

	initial begin
		int n;
		int settings [6][3];
		pixel_t z;
		errors = 0;
		beats_in = 0;
		beats_out = 0;
		hold_off = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_HUE_SHIFT;
		cfg_data = '0;
		hue_deg = 0;
		sat_pct = 0;
		light_pct = 0;
		z = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset settings. With zero shift and amounts,
		// black, white and pure primaries come back unchanged.
		dir_rows.push_back('{pixel_t'({16'h0000, 16'h0000, 16'h0000}), 1,
		                     pixel_t'({16'h0000, 16'h0000, 16'h0000})});
		dir_rows.push_back('{pixel_t'({16'hffff, 16'hffff, 16'hffff}), 1,
		                     pixel_t'({16'hffff, 16'hffff, 16'hffff})});
		dir_rows.push_back('{pixel_t'({16'h0000, 16'h0000, 16'hffff}), 1,
		                     pixel_t'({16'h0000, 16'h0000, 16'hffff})});
		dir_rows.push_back('{pixel_t'({16'h0000, 16'hffff, 16'h0000}), 1,
		                     pixel_t'({16'h0000, 16'hffff, 16'h0000})});
		dir_rows.push_back('{pixel_t'({16'hffff, 16'h0000, 16'h0000}), 1,
		                     pixel_t'({16'hffff, 16'h0000, 16'h0000})});
		dir_rows.push_back('{pixel_t'({16'h8000, 16'h8000, 16'h8000}), 0, z});
		dir_rows.push_back('{pixel_t'({16'h0000, 16'hffff, 16'hffff}), 0, z});
		dir_rows.push_back('{pixel_t'({16'h1234, 16'hffff, 16'hffff}), 0, z});
		dir_rows.push_back('{pixel_t'({16'hffff, 16'hffff, 16'h0001}), 0, z});
		dir_rows.push_back('{pixel_t'({16'h0001, 16'h0000, 16'h0000}), 0, z});
		dir_rows.push_back('{pixel_t'({16'h5555, 16'haaaa, 16'h0000}), 0, z});
		dir_rows.push_back('{pixel_t'({16'h7fff, 16'h8000, 16'h7ffe}), 0, z});
		foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, dir_rows[i].known,
		                                  dir_rows[i].want, 1'b0);
		drain();

		// Gray pixels with full saturation push get tinted; extreme amounts and
		// raw values beyond the documented range are exercised as well.
		settings = '{'{180, 100, 100}, '{-180, -100, -100}, '{255, 127, -128},
		             '{-256, -128, 127}, '{90, 50, -30}, '{0, 0, 0}};
		for (int s = 0; s < 6; s++) begin
			set_all(settings[s][0], settings[s][1], settings[s][2]);
			foreach (dir_rows[i]) begin
				if (i < 8) send_pixel(dir_rows[i].pix, 1'b0, z, 1'b0);
			end
			// Random part for this setting.
			n = (s == 5) ? 250 : 150;
			for (int i = 0; i < n; i++) begin
				if (s == 2 && i == 20) begin
					// Long receiver hold-off while the sender keeps offering beats,
					// so the pipeline fills and stalls its input.
					fork
						begin
							hold_off = 1'b1;
							repeat (80) @(posedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
				if (s == 3 && i == 75) begin
					// Sender pauses until every expected result has arrived.
					s_axis_tvalid <= 1'b0;
					while (adjusted_q.size() != 0) @(posedge clk);
				end
				send_pixel(rand_pixel(), 1'b0, z, i > 40);
			end
			drain();
			// An unused register index must be ignored.
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= 2'd3;
			cfg_data  <= 9'h1ff;
			@(posedge clk);
			cfg_wr_en <= 1'b0;
		end

		$display("Covered %0d pixels in, %0d out, over seven register settings",
		         beats_in, beats_out);
		$display("including extreme shifts and amounts, gray and tied pixels, and stalls.");
		if (errors == 0 && adjusted_q.size() == 0) begin
			$display("PASS hsl_pixel_adjust");
		end else begin
			$display("FAIL hsl_pixel_adjust");
		end
		$finish;
	end

endmodule

`default_nettype wire
